// ----- sv/connection_slot_table_assert.svh -----
// ----------------------------------------------------------------------------
// Connection slot table assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_SLOT_TABLE_ASSERT_SVH
`define CONNECTION_SLOT_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CST_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("connection_slot_table: assertion failed");
`define CST_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("connection_slot_table: forbidden condition");
`else
`define CST_ASSERT(label, prop)
`define CST_ASSERT_NEVER(label, expr)
`endif

`endif

// ----- sv/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// Connection slot table package
// Sizes, command codes and the control/status bundles shared by the modules.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CMD_W       = 3;
  localparam int HANDLE_W    = 12;
  localparam int SID_W       = 8;
  localparam int ID_W        = 7;
  localparam int CNT_W       = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ASSIGN = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_HANDLE = 3'd3,
    CMD_LIST   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic load_in;
    logic exec_op;
    logic load_hit;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_list;
    logic list_empty;
    logic scan_hit;
    logic out_last;
  } dp_status_t;

endpackage

// ----- sv/cst_datapath.sv -----
// ----------------------------------------------------------------------------
// Connection slot table datapath
// Slot store, occupancy count, scan pointer and the result register.
// ----------------------------------------------------------------------------
module cst_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cst_pkg::ctrl_cmd_t      ctl_i,
  output cst_pkg::dp_status_t     status_o,
  input  logic [cst_pkg::CMD_W-1:0]    cmd_i,
  input  logic [cst_pkg::HANDLE_W-1:0] conn_handle_i,
  input  logic [cst_pkg::SID_W-1:0]    short_id_i,
  output logic                         found_o,
  output logic [cst_pkg::ID_W-1:0]     result_id_o,
  output logic [cst_pkg::HANDLE_W-1:0] result_handle_o,
  output logic                         last_o,
  output logic                         full_res_o,
  output logic                         empty_res_o,
  output logic [cst_pkg::CNT_W-1:0]    occupied_count_o
);
  import cst_pkg::*;

  function automatic logic [IDX_W-1:0] first_set(input logic [SLOT_COUNT-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  logic [SLOT_COUNT-1:0] occ_q, occ_d;
  logic [HANDLE_W-1:0]   hmem_q [SLOT_COUNT];
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  cmd_e                  op_q;
  logic [HANDLE_W-1:0]   hdl_q;
  logic [SID_W-1:0]      sid_q;
  logic [IDX_W-1:0]      ptr_q;

  logic                  found_q;
  logic [ID_W-1:0]       id_q;
  logic [HANDLE_W-1:0]   rhdl_q;
  logic                  last_q;
  logic [CNT_W-1:0]      cnt_out_q;

  logic [SLOT_COUNT-1:0] free_vec, match_vec, excl_vec, qual_vec, above_vec;
  logic [IDX_W-1:0]      free_idx, match_idx;
  logic                  sid_ok, wr_en, more;
  logic                  nf;
  logic [ID_W-1:0]       nid;
  logic [HANDLE_W-1:0]   nh;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match_vec[i] = occ_q[i] && (hmem_q[i] == hdl_q);
      excl_vec[i]  = (sid_q == SID_W'(i + 1));
      above_vec[i] = (IDX_W'(i) > ptr_q);
    end
  end

  assign free_vec  = ~occ_q;
  assign free_idx  = first_set(free_vec);
  assign match_idx = first_set(match_vec);
  assign qual_vec  = occ_q & ~excl_vec;
  assign more      = |(qual_vec & above_vec);
  assign sid_ok    = (sid_q != '0) && (sid_q <= SID_W'(SLOT_COUNT));

  always_comb begin
    occ_d = occ_q;
    cnt_d = cnt_q;
    wr_en = 1'b0;
    nf    = 1'b0;
    nid   = '0;
    nh    = '0;
    case (op_q)
      CMD_ASSIGN: begin
        if (|free_vec) begin
          occ_d[free_idx] = 1'b1;
          cnt_d           = cnt_q + CNT_W'(1);
          wr_en           = 1'b1;
          nf              = 1'b1;
          nid             = ID_W'(free_idx) + ID_W'(1);
        end
      end
      CMD_FREE: begin
        if (|match_vec) begin
          occ_d[match_idx] = 1'b0;
          cnt_d            = cnt_q - CNT_W'(1);
          nf               = 1'b1;
          nid              = ID_W'(match_idx) + ID_W'(1);
        end
      end
      CMD_FIND: begin
        if (|match_vec) begin
          nf  = 1'b1;
          nid = ID_W'(match_idx) + ID_W'(1);
        end
      end
      CMD_HANDLE: begin
        if (sid_ok && occ_q[ptr_q]) begin
          nf  = 1'b1;
          nid = sid_q[ID_W-1:0];
          nh  = hmem_q[ptr_q];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      cnt_q <= '0;
    end else if (ctl_i.exec_op) begin
      occ_q <= occ_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      op_q  <= cmd_e'(cmd_i);
      hdl_q <= conn_handle_i;
      sid_q <= short_id_i;
      ptr_q <= (cmd_e'(cmd_i) == CMD_LIST) ? '0 : IDX_W'(short_id_i - SID_W'(1));
    end else if (ctl_i.advance) begin
      ptr_q <= ptr_q + IDX_W'(1);
    end

    if (ctl_i.exec_op && wr_en) begin
      hmem_q[free_idx] <= hdl_q;
    end

    if (ctl_i.exec_op) begin
      found_q   <= nf;
      id_q      <= nid;
      rhdl_q    <= nh;
      last_q    <= 1'b1;
      cnt_out_q <= cnt_d;
    end else if (ctl_i.load_hit) begin
      found_q   <= 1'b1;
      id_q      <= ID_W'(ptr_q) + ID_W'(1);
      rhdl_q    <= hmem_q[ptr_q];
      last_q    <= !more;
      cnt_out_q <= cnt_q;
    end
  end

  assign status_o.is_list    = (op_q == CMD_LIST);
  assign status_o.list_empty = (qual_vec == '0);
  assign status_o.scan_hit   = qual_vec[ptr_q];
  assign status_o.out_last   = last_q;

  assign found_o          = found_q;
  assign result_id_o      = id_q;
  assign result_handle_o  = rhdl_q;
  assign last_o           = last_q;
  assign occupied_count_o = cnt_out_q;
  assign full_res_o       = (cnt_out_q == CNT_W'(SLOT_COUNT));
  assign empty_res_o      = (cnt_out_q == '0);

endmodule

// ----- sv/cst_ctrl.sv -----
// ----------------------------------------------------------------------------
// Connection slot table controller
// Sequences accept, execute, list scan and result delivery.
// ----------------------------------------------------------------------------
module cst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  cst_pkg::dp_status_t status_i,
  output cst_pkg::ctrl_cmd_t  ctl_o
);
  import cst_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    ctl_o     = '0;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_list && !status_i.list_empty) begin
          state_d = ST_SCAN;
        end else begin
          ctl_o.exec_op = 1'b1;
          state_d       = ST_OUT;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_hit) begin
          ctl_o.load_hit = 1'b1;
          state_d        = ST_OUT;
        end else begin
          ctl_o.advance = 1'b1;
        end
      end
      ST_OUT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          if (status_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            ctl_o.advance = 1'b1;
            state_d       = ST_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/connection_slot_table.sv -----
// ----------------------------------------------------------------------------
// Connection slot table
// Maps link handles to short ids (slot index plus one) with first-free
// allocation, release, lookups in both directions and a listing command.
// ----------------------------------------------------------------------------
// One command is in flight at a time. Assign, free, id and handle lookups
// deliver their single item once the execute state has registered the
// result, and the next command is taken the cycle after that item is
// consumed. A list walks the slot table with a scan pointer, one slot per
// cycle while no listed item waits to be taken; when no slot qualifies it
// returns a single not-found item. Every item carries the occupancy count,
// full and empty as they stand after the command. Slot occupancy clears at
// reset; no clearing pass is needed.
`include "connection_slot_table_assert.svh"

module connection_slot_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [11:0] conn_handle, [19:12] short_id, [23:20] zero
  input  logic [cst_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [2:0] cmd
  input  logic [cst_pkg::CMD_W-1:0]          s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [6:0] result_id, [18:7] result_handle, [19] full_res, [20] empty_res,
  // [27:21] occupied_count, [31:28] zero
  output logic [cst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // [0] found
  output logic [0:0]                         m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);
  import cst_pkg::*;

  ctrl_cmd_t           ctl;
  dp_status_t          status;
  logic                found;
  logic [ID_W-1:0]     result_id;
  logic [HANDLE_W-1:0] result_handle;
  logic                full_res, empty_res;
  logic [CNT_W-1:0]    occupied_count;

  cst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .ctl_o     (ctl)
  );

  cst_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .status_o         (status),
    .cmd_i            (s_axis_tuser_i),
    .conn_handle_i    (s_axis_tdata_i[HANDLE_W-1:0]),
    .short_id_i       (s_axis_tdata_i[HANDLE_W+SID_W-1:HANDLE_W]),
    .found_o          (found),
    .result_id_o      (result_id),
    .result_handle_o  (result_handle),
    .last_o           (m_axis_tlast_o),
    .full_res_o       (full_res),
    .empty_res_o      (empty_res),
    .occupied_count_o (occupied_count)
  );

  assign m_axis_tuser_o = found;
  assign m_axis_tdata_o = {
    (OUT_TDATA_W - ID_W - HANDLE_W - 2 - CNT_W)'(0),
    occupied_count, empty_res, full_res, result_handle, result_id
  };

  `CST_ASSERT_NEVER(a_one_item_at_a_time, s_axis_tready_o && m_axis_tvalid_o)
  `CST_ASSERT(a_miss_has_no_id, (m_axis_tvalid_o && !found) |-> (result_id == '0))
  `CST_ASSERT(a_full_matches_count,
              (m_axis_tvalid_o && full_res) |-> (occupied_count == CNT_W'(SLOT_COUNT)))
  `CST_ASSERT(a_id_in_range,
              m_axis_tvalid_o |-> (result_id <= ID_W'(SLOT_COUNT)))

endmodule
